### design/lud_pkg.sv
`default_nettype none

package lud_pkg;

	localparam int unsigned FOCAL_W = 20;
	localparam int unsigned COEF_W = 24;
	localparam int unsigned RECIP_W = 24;
	localparam int unsigned CFG_DATA_W = 24;
	localparam int unsigned CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FOCAL_X = 3'd0,
		REG_FOCAL_Y = 3'd1,
		REG_CENTER_X = 3'd2,
		REG_CENTER_Y = 3'd3,
		REG_RADIAL_K1 = 3'd4,
		REG_RADIAL_K2 = 3'd5,
		REG_TANG_P1 = 3'd6,
		REG_TANG_P2 = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [FOCAL_W-1:0] focal_x;
		logic [FOCAL_W-1:0] focal_y;
		logic [FOCAL_W-1:0] center_x;
		logic [FOCAL_W-1:0] center_y;
		logic signed [COEF_W-1:0] k1;
		logic signed [COEF_W-1:0] k2;
		logic signed [COEF_W-1:0] p1;
		logic signed [COEF_W-1:0] p2;
		logic [RECIP_W-1:0] recip_x;
		logic [RECIP_W-1:0] recip_y;
	} lud_cfg_t;

	function automatic logic signed [23:0] sat_s24(input logic signed [63:0] v);
		logic signed [23:0] r;
		if (v > 64'sd8388607) begin
			r = 24'sh7FFFFF;
		end else if (v < -64'sd8388608) begin
			r = 24'sh800000;
		end else begin
			r = v[23:0];
		end
		return r;
	endfunction

	function automatic logic signed [31:0] sat_s32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### design/lud_ram.sv
`default_nettype none

module lud_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 307200
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### design/lud_recip.sv
`default_nettype none

module lud_recip (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [lud_pkg::FOCAL_W-1:0] den,
	output logic busy,
	output logic [lud_pkg::RECIP_W-1:0] recip
);

	import lud_pkg::*;

	// Restoring division of 2^36 by the focal length, one quotient bit per cycle.
	localparam int unsigned QW = 37;
	localparam logic [5:0] LAST_STEP = 6'(QW - 1);

	logic busy_q;
	logic [5:0] cnt_q;
	logic [FOCAL_W-1:0] rem_q;
	logic [QW-1:0] quo_q;
	logic [FOCAL_W-1:0] den_q;
	logic [RECIP_W-1:0] recip_q;

	logic [FOCAL_W:0] rem_shift;
	logic take;
	logic [QW-1:0] quo_next;

	always_comb begin
		rem_shift = {rem_q, cnt_q == LAST_STEP};
		take = rem_shift >= {1'b0, den_q};
		quo_next = {quo_q[QW-2:0], take};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			recip_q <= '1;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= LAST_STEP;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd0) begin
				busy_q <= 1'b0;
				recip_q <= (quo_next[QW-1:RECIP_W] != '0) ? '1 : quo_next[RECIP_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= take ? FOCAL_W'(rem_shift - {1'b0, den_q}) : rem_shift[FOCAL_W-1:0];
			quo_q <= quo_next;
		end
	end

	assign busy = busy_q;
	assign recip = recip_q;

endmodule

`default_nettype wire

### design/lud_map.sv
`default_nettype none

module lud_map #(
	parameter int unsigned IMG_COLS = 640,
	parameter int unsigned IMG_ROWS = 480,
	parameter int RADIAL_K3 = 0
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [8:0] row,
	input wire logic [9:0] col,
	input wire lud_pkg::lud_cfg_t cfg,
	output logic vld,
	output logic outside,
	output logic [$clog2(IMG_ROWS*IMG_COLS)-1:0] addr
);

	import lud_pkg::*;

	localparam int unsigned AW = $clog2(IMG_ROWS * IMG_COLS);
	localparam int unsigned RW = $clog2(IMG_ROWS);
	localparam int unsigned CW = $clog2(IMG_COLS);
	localparam int unsigned NST = 16;
	localparam logic signed [23:0] K3 = 24'(RADIAL_K3);
	localparam logic signed [35:0] ROW_MAX = 36'(IMG_ROWS - 1);
	localparam logic signed [35:0] COL_MAX = 36'(IMG_COLS - 1);
	localparam logic [30:0] LIM31 = '1;

	// One item travels at a time, so a stage may read registers of any earlier stage.
	logic [NST:1] v_q;

	logic signed [21:0] dxi_s1, dyi_s1;
	logic signed [46:0] px_s2, py_s2;
	logic signed [23:0] x_s3, y_s3;
	logic signed [47:0] xxp_s4, yyp_s4, xyp_s4;
	logic signed [27:0] xy_s5;
	logic [27:0] xx_s5, yy_s5;
	logic [28:0] r2_s5;
	logic [57:0] r4p_s6;
	logic signed [55:0] t1x_s6, t2x_s6, t1y_s6, t2y_s6;
	logic [30:0] r4_s7;
	logic [59:0] r6p_s8;
	logic signed [55:0] a1_s8, a2_s8;
	logic [30:0] r6_s9;
	logic signed [55:0] a3_s10;
	logic signed [31:0] rad_s11;
	logic signed [55:0] mx_s12, my_s12;
	logic signed [31:0] dx_s13, dy_s13;
	logic signed [55:0] qx_s14, qy_s14;
	logic signed [35:0] pc_s15, pr_s15;
	logic out_s16;
	logic [AW-1:0] addr_s16;

	logic signed [63:0] xw, yw, sumw, radw, dxw, dyw, pcw, prw, npc, npr;
	logic signed [57:0] rsum;
	logic [29:0] tsx, tsy;

	always_comb begin
		xw = 64'(px_s2 >>> 16);
		yw = 64'(py_s2 >>> 16);
		tsx = {1'b0, r2_s5} + {1'b0, xx_s5, 1'b0};
		tsy = {1'b0, r2_s5} + {1'b0, yy_s5, 1'b0};
		rsum = 58'(a1_s8) + 58'(a2_s8) + 58'(a3_s10);
		sumw = 64'(rsum);
		radw = (sumw >>> 20) + 64'sd1048576;
		dxw = 64'(mx_s12 >>> 20) + (64'(t1x_s6 >>> 20) <<< 1) + 64'(t2x_s6 >>> 20);
		dyw = 64'(my_s12 >>> 20) + 64'(t1y_s6 >>> 20) + (64'(t2y_s6 >>> 20) <<< 1);
		pcw = 64'(qx_s14) + $signed({24'b0, cfg.center_x, 20'b0});
		prw = 64'(qy_s14) + $signed({24'b0, cfg.center_y, 20'b0});
		npc = -pcw;
		npr = -prw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[NST-1:1], start};
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dxi_s1 <= $signed({4'b0, col, 8'b0}) - $signed({2'b0, cfg.center_x});
			dyi_s1 <= $signed({5'b0, row, 8'b0}) - $signed({2'b0, cfg.center_y});
		end
		if (v_q[1]) begin
			px_s2 <= 47'(dxi_s1) * 47'($signed({1'b0, cfg.recip_x}));
			py_s2 <= 47'(dyi_s1) * 47'($signed({1'b0, cfg.recip_y}));
		end
		if (v_q[2]) begin
			x_s3 <= sat_s24(xw);
			y_s3 <= sat_s24(yw);
		end
		if (v_q[3]) begin
			xxp_s4 <= 48'(x_s3) * 48'(x_s3);
			yyp_s4 <= 48'(y_s3) * 48'(y_s3);
			xyp_s4 <= 48'(x_s3) * 48'(y_s3);
		end
		if (v_q[4]) begin
			xx_s5 <= xxp_s4[47:20];
			yy_s5 <= yyp_s4[47:20];
			xy_s5 <= xyp_s4[47:20];
			r2_s5 <= {1'b0, xxp_s4[47:20]} + {1'b0, yyp_s4[47:20]};
		end
		if (v_q[5]) begin
			r4p_s6 <= 58'(r2_s5) * 58'(r2_s5);
			t1x_s6 <= 56'(cfg.p1) * 56'(xy_s5);
			t2x_s6 <= 56'(cfg.p2) * 56'($signed({1'b0, tsx}));
			t1y_s6 <= 56'(cfg.p1) * 56'($signed({1'b0, tsy}));
			t2y_s6 <= 56'(cfg.p2) * 56'(xy_s5);
		end
		if (v_q[6]) begin
			r4_s7 <= (r4p_s6[57:51] != '0) ? LIM31 : r4p_s6[50:20];
		end
		if (v_q[7]) begin
			r6p_s8 <= 60'(r4_s7) * 60'(r2_s5);
			a1_s8 <= 56'(cfg.k1) * 56'($signed({1'b0, r2_s5}));
			a2_s8 <= 56'(cfg.k2) * 56'($signed({1'b0, r4_s7}));
		end
		if (v_q[8]) begin
			r6_s9 <= (r6p_s8[59:51] != '0) ? LIM31 : r6p_s8[50:20];
		end
		if (v_q[9]) begin
			a3_s10 <= 56'(K3) * 56'($signed({1'b0, r6_s9}));
		end
		if (v_q[10]) begin
			rad_s11 <= sat_s32(radw);
		end
		if (v_q[11]) begin
			mx_s12 <= 56'(x_s3) * 56'(rad_s11);
			my_s12 <= 56'(y_s3) * 56'(rad_s11);
		end
		if (v_q[12]) begin
			dx_s13 <= sat_s32(dxw);
			dy_s13 <= sat_s32(dyw);
		end
		if (v_q[13]) begin
			qx_s14 <= 56'(dx_s13) * 56'($signed({1'b0, cfg.focal_x}));
			qy_s14 <= 56'(dy_s13) * 56'($signed({1'b0, cfg.focal_y}));
		end
		if (v_q[14]) begin
			pc_s15 <= pcw[63] ? -36'(npc >>> 28) : 36'(pcw >>> 28);
			pr_s15 <= prw[63] ? -36'(npr >>> 28) : 36'(prw >>> 28);
		end
		if (v_q[15]) begin
			out_s16 <= pr_s15[35] || (pr_s15 > ROW_MAX) || pc_s15[35] || (pc_s15 > COL_MAX);
			addr_s16 <= AW'(pr_s15[RW-1:0]) * AW'(IMG_COLS) + AW'(pc_s15[CW-1:0]);
		end
	end

	assign vld = v_q[NST];
	assign outside = out_s16;
	assign addr = addr_s16;

endmodule

`default_nettype wire

### design/lens_undistort_remap_unit.sv
`default_nettype none

// Load beats are taken one per cycle while no request or reciprocal holds the input;
// in-range ones are written to the frame store on the next cycle. A request beat passes
// a 16 stage mapping pipeline, the frame store read, a result register and the output
// register, which waits for a free output slot; one request is in flight, so a new one
// is taken only once the last result has entered the output register.
// A focal length write runs a bit-serial reciprocal; input waits until it ends. Reset clears
// control state and sets the registers to their reset values; the frame store is not cleared.

module lens_undistort_remap_unit #(
	parameter int unsigned IMG_COLS = 640,
	parameter int unsigned IMG_ROWS = 480,
	parameter int RADIAL_K3 = 0
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [lud_pkg::CFG_IDX_W-1:0] cfg_addr,
	input wire logic [lud_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [31:0] s_axis_tdata, // pixel_row, pixel_col, in_value, zero pad
	input wire logic s_axis_tuser, // req_type
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	output logic [7:0] m_axis_tdata, // out_value
	output logic m_axis_tuser // outside
);

	import lud_pkg::*;

	localparam int unsigned AW = $clog2(IMG_ROWS * IMG_COLS);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MAP = 4'b0010,
		ST_READ = 4'b0100,
		ST_WAIT = 4'b1000
	} state_t;

	state_t state_q;
	lud_cfg_t cfg;
	logic [FOCAL_W-1:0] focal_x_q, focal_y_q, center_x_q, center_y_q;
	logic signed [COEF_W-1:0] k1_q, k2_q, p1_q, p2_q;
	logic busy_x, busy_y;
	logic [RECIP_W-1:0] recip_x, recip_y;

	logic [8:0] in_row;
	logic [9:0] in_col;
	logic [7:0] in_val;
	logic acc, acc_req, acc_load, load_ok;

	logic we_q;
	logic [AW-1:0] waddr_q;
	logic [7:0] wdata_q;
	logic [7:0] rdata;

	logic map_vld, map_out;
	logic [AW-1:0] map_addr;

	logic res_out_q;
	logic [7:0] res_val_q;
	logic m_valid_q, m_out_q;
	logic [7:0] m_data_q;
	logic slot_free;

	assign in_row = s_axis_tdata[8:0];
	assign in_col = s_axis_tdata[18:9];
	assign in_val = s_axis_tdata[26:19];

	assign s_axis_tready = (state_q == ST_IDLE) && !busy_x && !busy_y;
	assign acc = s_axis_tvalid && s_axis_tready;
	assign acc_req = acc && s_axis_tuser;
	assign acc_load = acc && !s_axis_tuser;
	assign load_ok = (32'(in_row) < IMG_ROWS) && (32'(in_col) < IMG_COLS);
	assign slot_free = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q <= FOCAL_W'(256);
			focal_y_q <= FOCAL_W'(256);
			center_x_q <= '0;
			center_y_q <= '0;
			k1_q <= '0;
			k2_q <= '0;
			p1_q <= '0;
			p2_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_FOCAL_X: focal_x_q <= cfg_wdata[FOCAL_W-1:0];
				REG_FOCAL_Y: focal_y_q <= cfg_wdata[FOCAL_W-1:0];
				REG_CENTER_X: center_x_q <= cfg_wdata[FOCAL_W-1:0];
				REG_CENTER_Y: center_y_q <= cfg_wdata[FOCAL_W-1:0];
				REG_RADIAL_K1: k1_q <= cfg_wdata;
				REG_RADIAL_K2: k2_q <= cfg_wdata;
				REG_TANG_P1: p1_q <= cfg_wdata;
				REG_TANG_P2: p2_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	lud_recip u_recip_x (
		.clk(clk),
		.arst_n(arst_n),
		.start(cfg_we && (cfg_addr == REG_FOCAL_X)),
		.den(cfg_wdata[FOCAL_W-1:0]),
		.busy(busy_x),
		.recip(recip_x)
	);

	lud_recip u_recip_y (
		.clk(clk),
		.arst_n(arst_n),
		.start(cfg_we && (cfg_addr == REG_FOCAL_Y)),
		.den(cfg_wdata[FOCAL_W-1:0]),
		.busy(busy_y),
		.recip(recip_y)
	);

	always_comb begin
		cfg.focal_x = focal_x_q;
		cfg.focal_y = focal_y_q;
		cfg.center_x = center_x_q;
		cfg.center_y = center_y_q;
		cfg.k1 = k1_q;
		cfg.k2 = k2_q;
		cfg.p1 = p1_q;
		cfg.p2 = p2_q;
		cfg.recip_x = recip_x;
		cfg.recip_y = recip_y;
	end

	lud_map #(
		.IMG_COLS(IMG_COLS),
		.IMG_ROWS(IMG_ROWS),
		.RADIAL_K3(RADIAL_K3)
	) u_map (
		.clk(clk),
		.arst_n(arst_n),
		.start(acc_req),
		.row(in_row),
		.col(in_col),
		.cfg(cfg),
		.vld(map_vld),
		.outside(map_out),
		.addr(map_addr)
	);

	lud_ram #(
		.WIDTH(8),
		.DEPTH(IMG_ROWS * IMG_COLS)
	) u_frame (
		.clk(clk),
		.we(we_q),
		.waddr(waddr_q),
		.wdata(wdata_q),
		.re(map_vld),
		.raddr(map_addr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			we_q <= 1'b0;
		end else begin
			we_q <= acc_load && load_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_load) begin
			waddr_q <= AW'(in_row) * AW'(IMG_COLS) + AW'(in_col);
			wdata_q <= in_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_WAIT) && slot_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc_req) begin
						state_q <= ST_MAP;
					end
				end
				ST_MAP: begin
					if (map_vld) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			res_out_q <= map_out;
			res_val_q <= map_out ? 8'd0 : rdata;
		end
		if ((state_q == ST_WAIT) && slot_free) begin
			m_data_q <= res_val_q;
			m_out_q <= res_out_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = m_data_q;
	assign m_axis_tuser = m_out_q;

`ifndef SYNTHESIS
	a_map_only_in_map: assert property (@(posedge clk) disable iff (!arst_n)
		map_vld |-> (state_q == ST_MAP))
		else $error("mapping result arrived outside the mapping phase");
	a_no_accept_div: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_x || busy_y) |-> !s_axis_tready)
		else $error("input accepted while a reciprocal is running");
	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 8'd0))
		else $error("outside result carries a nonzero value");
	a_wait_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_WAIT) && m_valid_q && !m_axis_tready) |=> (state_q == ST_WAIT))
		else $error("result left the wait state while the output was full");
`endif

endmodule

`default_nettype wire

### sim/tb.sv
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lud_pkg::*;

	localparam int COLS = 640;
	localparam int ROWS = 480;
	localparam longint K3 = 0;
	localparam int STALL_LIMIT = 5000;

	typedef struct {
		logic [7:0] value;
		logic outside;
	} pix_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [31:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic m_tuser;

	bit calm = 1'b0;
	int errors = 0;
	int stall_cycles = 0;

	longint focal_x, focal_y, center_x, center_y, recip_x, recip_y;
	longint k1, k2, p1, p2;
	byte unsigned frame_mem [int];
	pix_result_t pending_pixels [$];

	lens_undistort_remap_unit #(
		.IMG_COLS(COLS),
		.IMG_ROWS(ROWS),
		.RADIAL_K3(0)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_tvalid),
		.s_axis_tready(s_tready),
		.s_axis_tdata(s_tdata),
		.s_axis_tuser(s_tuser),
		.m_axis_tvalid(m_tvalid),
		.m_axis_tready(m_tready),
		.m_axis_tdata(m_tdata),
		.m_axis_tuser(m_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= calm || ($urandom_range(99) >= 11);
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected result value=%0d outside=%0d", $time, m_tdata, m_tuser);
				errors++;
			end else begin
				pix_result_t e;
				e = pending_pixels.pop_front();
				if (m_tdata !== e.value) begin
					$display("%0t: out_value expected %0d actual %0d", $time, e.value, m_tdata);
					errors++;
				end
				if (m_tuser !== e.outside) begin
					$display("%0t: outside expected %0d actual %0d", $time, e.outside, m_tuser);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !arst_n) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint focal_recip(input longint f);
		longint q;
		if (f == 0) begin
			return 64'hFFFFFF;
		end
		q = (64'd1 << 36) / f;
		return q > 64'hFFFFFF ? 64'hFFFFFF : q;
	endfunction

	function automatic longint project(input longint d, input longint f, input longint c);
		longint p;
		p = d * f + (c << 20);
		if (p >= 0) begin
			return p >>> 28;
		end
		return -((-p) >>> 28);
	endfunction

	function automatic void source_position(input int row, input int col,
			output longint src_row, output longint src_col);
		longint x, y, xx, yy, xy, r2, r4, r6, rad, dx, dy;
		longint lim;
		lim = (64'sd1 <<< 31) - 1;
		x = clip(((longint'(col) * 256 - center_x) * recip_x) >>> 16, -8388608, 8388607);
		y = clip(((longint'(row) * 256 - center_y) * recip_y) >>> 16, -8388608, 8388607);
		xx = (x * x) >>> 20;
		yy = (y * y) >>> 20;
		xy = (x * y) >>> 20;
		r2 = clip(xx + yy, 0, lim);
		r4 = clip((r2 * r2) >>> 20, 0, lim);
		r6 = clip((r4 * r2) >>> 20, 0, lim);
		rad = clip((64'sd1 <<< 20) + ((k1 * r2 + k2 * r4 + K3 * r6) >>> 20), -lim - 1, lim);
		dx = ((x * rad) >>> 20) + 2 * ((p1 * xy) >>> 20) + ((p2 * (r2 + 2 * xx)) >>> 20);
		dy = ((y * rad) >>> 20) + ((p1 * (r2 + 2 * yy)) >>> 20) + 2 * ((p2 * xy) >>> 20);
		dx = clip(dx, -lim - 1, lim);
		dy = clip(dy, -lim - 1, lim);
		src_col = project(dx, focal_x, center_x);
		src_row = project(dy, focal_y, center_y);
	endfunction

	task automatic send_beat(input bit is_req, input int row, input int col, input int val);
		longint sr, sc;
		pix_result_t e;
		if (!calm && $urandom_range(99) < 11) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= is_req;
		s_tdata <= {5'b0, val[7:0], col[9:0], row[8:0]};
		do @(posedge clk); while (!s_tready);
		if (!is_req) begin
			if (row < ROWS && col < COLS) begin
				frame_mem[row * COLS + col] = val[7:0];
			end
		end else begin
			source_position(row, col, sr, sc);
			if (sr < 0 || sr > ROWS - 1 || sc < 0 || sc > COLS - 1) begin
				e.value = 8'd0;
				e.outside = 1'b1;
			end else begin
				e.value = frame_mem[int'(sr) * COLS + int'(sc)];
				e.outside = 1'b0;
			end
			pending_pixels.push_back(e);
		end
	endtask

	// A request whose in-range source pixel was never loaded gets that pixel loaded first.
	task automatic request_pixel(input int row, input int col);
		longint sr, sc;
		source_position(row, col, sr, sc);
		if (sr >= 0 && sr < ROWS && sc >= 0 && sc < COLS
				&& !frame_mem.exists(int'(sr) * COLS + int'(sc))) begin
			send_beat(1'b0, int'(sr), int'(sc), $urandom_range(255));
		end
		send_beat(1'b1, row, col, $urandom_range(255));
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [23:0] v);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_FOCAL_X: begin focal_x = v[19:0]; recip_x = focal_recip(focal_x); end
			REG_FOCAL_Y: begin focal_y = v[19:0]; recip_y = focal_recip(focal_y); end
			REG_CENTER_X: center_x = v[19:0];
			REG_CENTER_Y: center_y = v[19:0];
			REG_RADIAL_K1: k1 = longint'(signed'(v));
			REG_RADIAL_K2: k2 = longint'(signed'(v));
			REG_TANG_P1: p1 = longint'(signed'(v));
			REG_TANG_P2: p2 = longint'(signed'(v));
			default: ;
		endcase
		repeat (2) @(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic set_lens(input int fx, input int fy, input int cx, input int cy,
			input int a, input int b, input int c, input int d);
		drain();
		write_reg(REG_FOCAL_X, fx);
		write_reg(REG_FOCAL_Y, fy);
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		write_reg(REG_RADIAL_K1, a);
		write_reg(REG_RADIAL_K2, b);
		write_reg(REG_TANG_P1, c);
		write_reg(REG_TANG_P2, d);
	endtask

	task automatic random_traffic(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 30) begin
				if ($urandom_range(9) == 0) begin
					send_beat(1'b0, $urandom_range(511), $urandom_range(1023), $urandom_range(255));
				end else begin
					send_beat(1'b0, $urandom_range(ROWS - 1), $urandom_range(COLS - 1),
						$urandom_range(255));
				end
			end else if ($urandom_range(9) == 0) begin
				request_pixel($urandom_range(511), $urandom_range(1023));
			end else begin
				request_pixel($urandom_range(ROWS - 1), $urandom_range(COLS - 1));
			end
		end
	endtask

	task automatic test_reset_values;
		send_beat(1'b0, 0, 0, 8'hFF);
		send_beat(1'b0, ROWS - 1, COLS - 1, 8'h00);
		send_beat(1'b0, 511, 1023, 8'hA5);
		send_beat(1'b0, ROWS, 0, 8'h5A);
		send_beat(1'b0, 0, COLS, 8'h5A);
		request_pixel(0, 0);
		request_pixel(0, 1);
		request_pixel(1, 0);
		request_pixel(ROWS - 1, COLS - 1);
		request_pixel(511, 1023);
	endtask

	task automatic test_directed_lens;
		set_lens(500 << 8, 500 << 8, 320 << 8, 240 << 8, 0, 0, 0, 0);
		send_beat(1'b0, 240, 320, 8'hC3);
		send_beat(1'b1, 240, 320, 8'hFF);
		request_pixel(0, 0);
		request_pixel(ROWS - 1, COLS - 1);
		request_pixel(511, 1023);
		set_lens(1, 24'hFFFFF, 24'hFFFFF, 0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
		request_pixel(0, 0);
		request_pixel(ROWS - 1, COLS - 1);
		request_pixel(511, 1023);
		set_lens(0, 0, 0, 24'hFFFFF, 24'h800000, 24'h800000, 24'h800000, 24'h800000);
		request_pixel(0, 0);
		request_pixel(ROWS - 1, COLS - 1);
		request_pixel(511, 1023);
		request_pixel(100, 200);
	endtask

	task automatic test_random_lens(input int phases, input int count);
		for (int ph = 0; ph < phases; ph++) begin
			set_lens($urandom_range(200 << 8, 900 << 8), $urandom_range(200 << 8, 900 << 8),
				$urandom_range(250 << 8, 390 << 8), $urandom_range(180 << 8, 300 << 8),
				$urandom_range(629144) - 314572, $urandom_range(209715) - 104857,
				$urandom_range(20970) - 10485, $urandom_range(20970) - 10485);
			random_traffic(count);
		end
	endtask

	task automatic test_drained_pause;
		random_traffic(40);
		s_tvalid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		random_traffic(40);
	endtask

	task automatic test_no_idle;
		calm = 1'b1;
		random_traffic(150);
		calm = 1'b0;
	endtask

	initial begin
		focal_x = 256;
		focal_y = 256;
		center_x = 0;
		center_y = 0;
		recip_x = focal_recip(256);
		recip_y = focal_recip(256);
		k1 = 0;
		k2 = 0;
		p1 = 0;
		p2 = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_directed_lens();
		test_random_lens(4, 120);
		test_drained_pause();
		test_no_idle();
		test_random_lens(1, 120);
		drain();
		repeat (25) @(posedge clk);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
